@@ rtl/tbp_pkg.sv @@
// types, command codes and helpers shared by the turtle bitmap plotter
package tbp_pkg;

    localparam int REQ_W      = 3;
    localparam int DIST_W     = 8;
    localparam int ROW_BITS_W = 64;
    localparam int ROW_NUM_W  = 5;
    // wide enough for a grid index (up to 63) plus the largest distance
    localparam int SUM_W      = 9;
    localparam int LANE_W     = 6;

    localparam logic [REQ_W-1:0] REQ_PEN_UP     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PEN_DOWN   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TURN_RIGHT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TURN_LEFT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_MOVE       = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DISPLAY    = 3'd5;

    typedef enum logic [1:0] {
        HEAD_EAST  = 2'd0,
        HEAD_SOUTH = 2'd1,
        HEAD_WEST  = 2'd2,
        HEAD_NORTH = 2'd3
    } heading_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_WR,
        ST_DISP_RD,
        ST_DISP_LD
    } state_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [DIST_W-1:0] distance;
    } req_item_t;

    typedef struct packed {
        logic [ROW_BITS_W-1:0] row_bits;
        logic [ROW_NUM_W-1:0]  row_number;
        logic                  last_row;
    } row_item_t;

    typedef struct packed {
        logic accept;
        logic walk_rd;
        logic walk_wr;
        logic disp_first;
        logic disp_load;
    } cmd_t;

    typedef struct packed {
        logic need_walk;
        logic walk_last;
        logic disp_last;
        logic out_free;
    } status_t;

    // ones from column lo up to column hi inclusive
    function automatic logic [ROW_BITS_W-1:0] span_mask(input logic [LANE_W-1:0] lo,
                                                        input logic [LANE_W-1:0] hi);
        logic [ROW_BITS_W-1:0] low_part;
        logic [ROW_BITS_W-1:0] high_part;
        low_part  = {ROW_BITS_W{1'b1}} << lo;
        high_part = {ROW_BITS_W{1'b1}} >> (LANE_W'(ROW_BITS_W - 1) - hi);
        return low_part & high_part;
    endfunction

endpackage

@@ rtl/tbp_ctrl.sv @@
// command sequencer: decodes beats and steps the row walk and display scan
module tbp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  tbp_pkg::req_item_t  s_data,
    output logic                s_ready,
    input  tbp_pkg::status_t    status,
    output tbp_pkg::cmd_t       cmd
);

    tbp_pkg::state_t state_reg;
    tbp_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tbp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tbp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.req_type)
                        tbp_pkg::REQ_MOVE: begin
                            if (status.need_walk) begin
                                state_next = tbp_pkg::ST_WALK_RD;
                            end
                        end
                        tbp_pkg::REQ_DISPLAY: begin
                            state_next = tbp_pkg::ST_DISP_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tbp_pkg::ST_WALK_RD: begin
                state_next = tbp_pkg::ST_WALK_WR;
            end
            tbp_pkg::ST_WALK_WR: begin
                if (status.walk_last) begin
                    state_next = tbp_pkg::ST_IDLE;
                end
            end
            tbp_pkg::ST_DISP_RD: begin
                state_next = tbp_pkg::ST_DISP_LD;
            end
            tbp_pkg::ST_DISP_LD: begin
                if (status.out_free && status.disp_last) begin
                    state_next = tbp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready        = (state_reg == tbp_pkg::ST_IDLE);
        cmd.accept     = (state_reg == tbp_pkg::ST_IDLE) && s_valid;
        cmd.walk_rd    = (state_reg == tbp_pkg::ST_WALK_RD);
        cmd.walk_wr    = (state_reg == tbp_pkg::ST_WALK_WR);
        cmd.disp_first = (state_reg == tbp_pkg::ST_DISP_RD);
        cmd.disp_load  = (state_reg == tbp_pkg::ST_DISP_LD) && status.out_free;
    end

endmodule

@@ rtl/tbp_datapath.sv @@
// turtle position, heading, pen, floor memory and result register
module tbp_datapath #(
    parameter int GRID_ROWS = 32,
    parameter int GRID_COLS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tbp_pkg::cmd_t       cmd,
    output tbp_pkg::status_t    status,
    input  tbp_pkg::req_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tbp_pkg::row_item_t  m_data
);

    localparam int ROW_W = $clog2(GRID_ROWS);
    localparam int COL_W = $clog2(GRID_COLS);
    localparam int SUM_W = tbp_pkg::SUM_W;
    localparam int BITS_W = tbp_pkg::ROW_BITS_W;
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(GRID_ROWS - 1);
    localparam logic [COL_W-1:0] COL_MAX = COL_W'(GRID_COLS - 1);
    localparam logic [SUM_W-1:0] ROW_MAX_S = SUM_W'(GRID_ROWS - 1);
    localparam logic [SUM_W-1:0] COL_MAX_S = SUM_W'(GRID_COLS - 1);
    localparam logic [BITS_W-1:0] COL_MASK =
        (GRID_COLS >= BITS_W) ? {BITS_W{1'b1}} : ((BITS_W'(1) << GRID_COLS) - BITS_W'(1));

    logic [BITS_W-1:0] floor_mem [GRID_ROWS];
    logic [GRID_ROWS-1:0] row_valid_reg;
    logic [BITS_W-1:0] rd_data_reg;
    logic              rd_valid_reg;

    logic [ROW_W-1:0]  pos_row_reg, pos_row_next;
    logic [COL_W-1:0]  pos_col_reg, pos_col_next;
    tbp_pkg::heading_t heading_reg, heading_next;
    logic              pen_reg, pen_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]  end_row_reg, end_row_next;
    logic [BITS_W-1:0] mark_mask_reg, mark_mask_next;
    logic              step_up_reg, step_up_next;
    logic              m_valid_reg, m_valid_next;
    tbp_pkg::row_item_t m_data_reg, m_data_next;

    logic              rd_en;
    logic [ROW_W-1:0]  rd_addr;
    logic              wr_en;
    logic [BITS_W-1:0] wr_data;

    logic [SUM_W-1:0]  dist_s, dist_m1, col_s, row_s;
    logic [SUM_W-1:0]  col_fwd, col_fwd_m1, row_fwd, row_fwd_m1;
    logic [COL_W-1:0]  new_col_e, hi_e, new_col_w, lo_w;
    logic [ROW_W-1:0]  new_row_s, end_s, new_row_n, end_n;
    logic [ROW_W-1:0]  cur_step;
    logic [BITS_W-1:0] col_bit;

    // clamped targets and marked span for each heading
    always_comb begin
        dist_s     = SUM_W'(s_data.distance);
        dist_m1    = dist_s - SUM_W'(1);
        col_s      = SUM_W'(pos_col_reg);
        row_s      = SUM_W'(pos_row_reg);
        col_fwd    = col_s + dist_s;
        col_fwd_m1 = col_s + dist_m1;
        row_fwd    = row_s + dist_s;
        row_fwd_m1 = row_s + dist_m1;
        new_col_e  = (col_fwd > COL_MAX_S) ? COL_MAX : COL_W'(col_fwd);
        hi_e       = (col_fwd_m1 > COL_MAX_S) ? COL_MAX : COL_W'(col_fwd_m1);
        new_col_w  = (dist_s > col_s) ? '0 : COL_W'(col_s - dist_s);
        lo_w       = (dist_m1 > col_s) ? '0 : COL_W'(col_s - dist_m1);
        new_row_s  = (row_fwd > ROW_MAX_S) ? ROW_MAX : ROW_W'(row_fwd);
        end_s      = (row_fwd_m1 > ROW_MAX_S) ? ROW_MAX : ROW_W'(row_fwd_m1);
        new_row_n  = (dist_s > row_s) ? '0 : ROW_W'(row_s - dist_s);
        end_n      = (dist_m1 > row_s) ? '0 : ROW_W'(row_s - dist_m1);
        col_bit    = BITS_W'(1) << pos_col_reg;
        cur_step   = step_up_reg ? (cur_row_reg + ROW_W'(1)) : (cur_row_reg - ROW_W'(1));
    end

    always_comb begin
        status.need_walk = pen_reg && (s_data.distance != '0);
        status.walk_last = (cur_row_reg == end_row_reg);
        status.disp_last = (cur_row_reg == ROW_MAX);
        status.out_free  = !m_valid_reg || m_ready;
    end

    always_comb begin
        pos_row_next   = pos_row_reg;
        pos_col_next   = pos_col_reg;
        heading_next   = heading_reg;
        pen_next       = pen_reg;
        cur_row_next   = cur_row_reg;
        end_row_next   = end_row_reg;
        mark_mask_next = mark_mask_reg;
        step_up_next   = step_up_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg;
        rd_en          = 1'b0;
        rd_addr        = cur_row_reg;
        wr_en          = 1'b0;
        wr_data        = (rd_valid_reg ? rd_data_reg : '0) | mark_mask_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cmd.accept) begin
            case (s_data.req_type)
                tbp_pkg::REQ_PEN_UP: begin
                    pen_next = 1'b0;
                end
                tbp_pkg::REQ_PEN_DOWN: begin
                    pen_next = 1'b1;
                end
                tbp_pkg::REQ_TURN_RIGHT: begin
                    heading_next = tbp_pkg::heading_t'(2'(heading_reg + 2'd1));
                end
                tbp_pkg::REQ_TURN_LEFT: begin
                    heading_next = tbp_pkg::heading_t'(2'(heading_reg + 2'd3));
                end
                tbp_pkg::REQ_MOVE: begin
                    // horizontal moves touch one row, vertical ones a column of rows
                    case (heading_reg)
                        tbp_pkg::HEAD_EAST: begin
                            pos_col_next   = new_col_e;
                            cur_row_next   = pos_row_reg;
                            end_row_next   = pos_row_reg;
                            mark_mask_next = tbp_pkg::span_mask(tbp_pkg::LANE_W'(pos_col_reg),
                                                                tbp_pkg::LANE_W'(hi_e));
                        end
                        tbp_pkg::HEAD_WEST: begin
                            pos_col_next   = new_col_w;
                            cur_row_next   = pos_row_reg;
                            end_row_next   = pos_row_reg;
                            mark_mask_next = tbp_pkg::span_mask(tbp_pkg::LANE_W'(lo_w),
                                                                tbp_pkg::LANE_W'(pos_col_reg));
                        end
                        tbp_pkg::HEAD_SOUTH: begin
                            pos_row_next   = new_row_s;
                            cur_row_next   = pos_row_reg;
                            end_row_next   = end_s;
                            step_up_next   = 1'b1;
                            mark_mask_next = col_bit;
                        end
                        default: begin
                            pos_row_next   = new_row_n;
                            cur_row_next   = pos_row_reg;
                            end_row_next   = end_n;
                            step_up_next   = 1'b0;
                            mark_mask_next = col_bit;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end

        if (cmd.walk_rd) begin
            rd_en   = 1'b1;
            rd_addr = cur_row_reg;
        end

        // write this row and fetch the next one in the same cycle
        if (cmd.walk_wr) begin
            wr_en = 1'b1;
            if (!status.walk_last) begin
                cur_row_next = cur_step;
                rd_en        = 1'b1;
                rd_addr      = cur_step;
            end
        end

        if (cmd.disp_first) begin
            cur_row_next = '0;
            rd_en        = 1'b1;
            rd_addr      = '0;
        end

        if (cmd.disp_load) begin
            m_valid_next           = 1'b1;
            m_data_next.row_bits   = (rd_valid_reg ? rd_data_reg : '0) & COL_MASK;
            m_data_next.row_number = tbp_pkg::ROW_NUM_W'(cur_row_reg);
            m_data_next.last_row   = status.disp_last;
            if (!status.disp_last) begin
                cur_row_next = cur_row_reg + ROW_W'(1);
                rd_en        = 1'b1;
                rd_addr      = cur_row_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_row_reg   <= '0;
            pos_col_reg   <= '0;
            heading_reg   <= tbp_pkg::HEAD_EAST;
            pen_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
            row_valid_reg <= '0;
        end else begin
            pos_row_reg <= pos_row_next;
            pos_col_reg <= pos_col_next;
            heading_reg <= heading_next;
            pen_reg     <= pen_next;
            m_valid_reg <= m_valid_next;
            if (wr_en) begin
                row_valid_reg[cur_row_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_row_reg   <= cur_row_next;
        end_row_reg   <= end_row_next;
        mark_mask_reg <= mark_mask_next;
        step_up_reg   <= step_up_next;
        m_data_reg    <= m_data_next;
    end

    // floor memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            floor_mem[cur_row_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= floor_mem[rd_addr];
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_pos_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_row_reg <= ROW_MAX)
        else $error("turtle row left the grid");

    a_pos_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_col_reg <= COL_MAX)
        else $error("turtle column left the grid");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.disp_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while stalled");

    a_last_row_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.disp_load && status.disp_last) |=> (m_valid_reg && m_data_reg.last_row))
        else $error("final row of display not flagged");

    a_walk_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_wr |-> (cur_row_reg <= ROW_MAX))
        else $error("row walk outside the floor");

endmodule

@@ rtl/turtle_bitmap_plotter.sv @@
// turtle graphics plotter on a bitmap floor: sequencer plus datapath
//
// usage: one command beat enters on s_* (req_type, distance); display
// commands return one m_* beat per floor row, row 0 first, with last_row
// set on the final one. other commands return nothing.
// pen up/down, turns, unknown codes, zero moves and pen-up moves are
// taken in the idle state and leave s_ready high. a pen-down move
// walks each row it touches (1 for east/west, up to GRID_ROWS for
// north/south); each touched row is one read-modify-write of the floor
// memory, with the next row fetched while the current one is written.
// display: when m_ready stays high, the single floor read port and the
// output register give one row per cycle. the first display beat
// follows the read state, then the load into the output register.
// a stalled m_ready holds the display scan on the current row; the final
// row may still wait in the output register while the next command enters.
// reset (aresetn low, synchronous) clears the floor at once through per-row
// valid bits, puts the turtle at row 0, column 0, heading east, pen up.
module turtle_bitmap_plotter #(
    parameter int GRID_ROWS = 32,
    parameter int GRID_COLS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tbp_pkg::req_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tbp_pkg::row_item_t  m_data
);

    tbp_pkg::cmd_t    cmd;
    tbp_pkg::status_t status;

    tbp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_data  (s_data),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tbp_datapath #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
